>>> rtl/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and constants for the merge sort engine core.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int unsigned SORT_DEPTH = 64;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CNT_W      = $clog2(SORT_DEPTH + 1);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]          count_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;    // insert the broadcast value in sorted position
    logic shift;  // move every value one cell toward the head
  } cell_ctrl_t;

endpackage

>>> rtl/merge_sort_engine_core.sv
// ----------------------------------------------------------------------------
// merge_sort_engine_core
// Stable ascending sort of signed 32-bit sets on a row of insertion cells.
// ----------------------------------------------------------------------------
// Load: one beat per cycle, each value inserted into the cell row on accept.
// Drain: after the closing beat, n sorted beats follow, one per cycle while
// out_stall_i is low, the first visible the cycle after the close; input is
// stalled while draining.
// Reset clears state and all cell occupied flags; the block then loads.
module merge_sort_engine_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [31:0]     element_value_i,
  input  logic                   set_end_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [31:0]     sorted_value_o,
  output logic                   run_end_o
);

  localparam int unsigned N = mse_pkg::SORT_DEPTH;

  mse_pkg::state_e     state_q, state_d;
  mse_pkg::count_t     count_q, count_d;
  mse_pkg::count_t     cnt_inc;
  mse_pkg::cell_ctrl_t ctrl;
  logic                in_acc, out_acc;

  mse_pkg::value_t cell_val   [N];
  logic            cell_valid [N];
  logic            cell_gt    [N];

  assign in_stall_o  = (state_q != mse_pkg::ST_LOAD);
  assign out_valid_o = (state_q == mse_pkg::ST_DRAIN);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign cnt_inc     = count_q + mse_pkg::count_t'(1);

  assign ctrl.ins    = in_acc;
  assign ctrl.shift  = out_acc;

  assign sorted_value_o = cell_val[0];
  assign run_end_o      = (count_q == mse_pkg::count_t'(1));

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    case (state_q)
      mse_pkg::ST_LOAD: begin
        if (in_acc) begin
          count_d = cnt_inc;
          if (set_end_i || cnt_inc == mse_pkg::count_t'(N)) begin
            state_d = mse_pkg::ST_DRAIN;
          end
        end
      end
      mse_pkg::ST_DRAIN: begin
        if (out_acc) begin
          count_d = count_q - mse_pkg::count_t'(1);
          if (count_q == mse_pkg::count_t'(1)) begin
            state_d = mse_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_d = mse_pkg::ST_LOAD;
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mse_pkg::ST_LOAD;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Cell 0 is the head (smallest value); the tail pulls in empty slots.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic            left_gt, left_valid, right_valid;
    mse_pkg::value_t left_val, right_val;

    if (i == 0) begin : g_head
      assign left_gt    = 1'b0;
      assign left_val   = '0;
      assign left_valid = 1'b0;
    end else begin : g_mid
      assign left_gt    = cell_gt[i-1];
      assign left_val   = cell_val[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_val   = '0;
      assign right_valid = 1'b0;
    end else begin : g_body
      assign right_val   = cell_val[i+1];
      assign right_valid = cell_valid[i+1];
    end

    mse_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_val_i     (element_value_i),
      .left_gt_i     (left_gt),
      .left_val_i    (left_val),
      .left_valid_i  (left_valid),
      .right_val_i   (right_val),
      .right_valid_i (right_valid),
      .val_o         (cell_val[i]),
      .valid_o       (cell_valid[i]),
      .gt_o          (cell_gt[i])
    );
  end

endmodule

>>> rtl/mse_cell.sv
// ----------------------------------------------------------------------------
// mse_cell
// One slot of the insertion sorter: holds a value and an occupied flag,
// compares against the broadcast value and takes from a neighbor on demand.
// ----------------------------------------------------------------------------
module mse_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mse_pkg::cell_ctrl_t ctrl_i,
  input  mse_pkg::value_t     new_val_i,
  input  logic                left_gt_i,
  input  mse_pkg::value_t     left_val_i,
  input  logic                left_valid_i,
  input  mse_pkg::value_t     right_val_i,
  input  logic                right_valid_i,
  output mse_pkg::value_t     val_o,
  output logic                valid_o,
  output logic                gt_o
);

  mse_pkg::value_t val_q, val_d;
  logic            valid_q, valid_d;

  // Strict compare keeps equal values in arrival order; empty slots rank last.
  assign gt_o    = !valid_q || (val_q > new_val_i);
  assign val_o   = val_q;
  assign valid_o = valid_q;

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.ins) begin
      if (left_gt_i) begin
        val_d   = left_val_i;
        valid_d = left_valid_i;
      end else if (gt_o) begin
        val_d   = new_val_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.shift) begin
      val_d   = right_val_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
